>>> src/fjsp_pkg.sv
// ----------------------------------------------------------------------------
// fjsp_pkg
// Types, codes and helper functions of the flat JSON object stream parser.
// ----------------------------------------------------------------------------
package fjsp_pkg;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned QUEUE_IW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned RESULT_IW   = $clog2(MAX_RESULTS);
   localparam int unsigned RESULT_CW   = $clog2(MAX_RESULTS + 1);

   typedef enum logic [3:0] {
      GS_OPEN   = 4'd0,
      GS_FIRST  = 4'd1,
      GS_KEY    = 4'd2,
      GS_STRING = 4'd3,
      GS_ESCAPE = 4'd4,
      GS_HEX    = 4'd5,
      GS_COLON  = 4'd6,
      GS_VALUE  = 4'd7,
      GS_AFTER  = 4'd8,
      GS_DONE   = 4'd9
   } grammar_state_type;

   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_ENTRY  = 2'd2,
      KIND_FINISH = 2'd3
   } out_kind_type;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   localparam logic [15:0] UTF8_MAX1 = 16'h007F;
   localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0]   out_byte;
      out_kind_type out_kind;
      logic         parse_status;
      logic         run_end;
   } rsp_item_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   // returns {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

>>> src/fjsp_if.sv
// ----------------------------------------------------------------------------
// fjsp_req_if / fjsp_rsp_if
// Valid/ready channels carrying input bytes and parser results.
// ----------------------------------------------------------------------------
interface fjsp_req_if;
   logic                  valid;
   logic                  ready;
   fjsp_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface fjsp_rsp_if;
   logic                  valid;
   logic                  ready;
   fjsp_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/flat_json_object_stream_parser.sv
// ----------------------------------------------------------------------------
// flat_json_object_stream_parser
// Parses a flat JSON object of string pairs byte by byte and emits decoded
// key and value bytes, entry marks and a final status.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       transfer
//  req_chan  in   text_byte, final_byte                          valid & ready
//  rsp_chan  out  out_byte, out_kind, parse_status, run_end      valid & ready
//
//  one input byte per cycle; it is held in an input register, decoded
//  combinationally into 0 to 4 results, and those go into an 8-entry result queue
//  the queue drains one result per cycle; input is taken while it holds
//  4 or fewer results, so a byte that makes several results is absorbed
//  synchronous reset returns the grammar to expecting an opening brace
//  and empties the queue; rsp stalls back up into req only through the queue
// ----------------------------------------------------------------------------
module flat_json_object_stream_parser (
   input  logic        clock,
   input  logic        reset,
   fjsp_req_if.sink    req_chan,
   fjsp_rsp_if.source  rsp_chan
);

   localparam logic [fjsp_pkg::QUEUE_CW-1:0] ACCEPT_LIMIT =
      fjsp_pkg::QUEUE_CW'(fjsp_pkg::QUEUE_DEPTH - fjsp_pkg::MAX_RESULTS);

   // input register
   logic                   in_valid_ff, in_valid_in;
   fjsp_pkg::req_item_type in_item_ff;

   // parser state
   fjsp_pkg::grammar_state_type gs_ff, gs_in;
   logic        in_value_ff, in_value_in;
   logic        khb_ff, khb_in;
   logic [15:0] hex_ff, hex_in;
   logic [1:0]  hex_seen_ff, hex_seen_in;
   logic        err_ff, err_in;

   // result queue
   fjsp_pkg::rsp_item_type               queue_ff [fjsp_pkg::QUEUE_DEPTH];
   fjsp_pkg::rsp_item_type               queue_in [fjsp_pkg::QUEUE_DEPTH];
   logic [fjsp_pkg::QUEUE_CW-1:0]        count_ff, count_in, count_pop;

   logic        move, pop;
   logic [7:0]  c;
   logic [4:0]  hexd;
   logic [15:0] code;
   logic [7:0]  str_byte [3];
   logic [1:0]  str_cnt;
   logic        str_emit;
   logic        entry, finish, bad;
   fjsp_pkg::out_kind_type        str_kind;
   fjsp_pkg::rsp_item_type        items [fjsp_pkg::MAX_RESULTS];
   logic [fjsp_pkg::RESULT_CW-1:0] n_items;

   assign move = in_valid_ff && (count_ff <= ACCEPT_LIMIT);
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || move;
   assign rsp_chan.valid = (count_ff != '0);
   assign rsp_chan.payload = queue_ff[0];
   assign in_valid_in = req_chan.valid || (in_valid_ff && !move);

   assign c    = in_item_ff.text_byte;
   assign hexd = fjsp_pkg::hex_value(c);
   assign code = {hex_ff[11:0], hexd[3:0]};

   // grammar and decode
   always_comb begin
      gs_in       = gs_ff;
      in_value_in = in_value_ff;
      khb_in      = khb_ff;
      hex_in      = hex_ff;
      hex_seen_in = hex_seen_ff;
      err_in      = err_ff;
      str_byte[0] = '0;
      str_byte[1] = '0;
      str_byte[2] = '0;
      str_cnt     = '0;
      entry       = 1'b0;
      finish      = 1'b0;
      bad         = 1'b0;
      if (move) begin
         if (!err_ff) begin
            unique case (gs_ff)
               fjsp_pkg::GS_OPEN: begin
                  if (!fjsp_pkg::is_space(c)) begin
                     if (c == fjsp_pkg::CH_LBRACE) gs_in = fjsp_pkg::GS_FIRST;
                     else err_in = 1'b1;
                  end
               end
               fjsp_pkg::GS_FIRST: begin
                  if (!fjsp_pkg::is_space(c)) begin
                     if (c == fjsp_pkg::CH_RBRACE) begin
                        gs_in = fjsp_pkg::GS_DONE;
                     end else if (c == fjsp_pkg::CH_QUOTE) begin
                        gs_in = fjsp_pkg::GS_STRING;
                        in_value_in = 1'b0;
                        khb_in = 1'b0;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
               end
               fjsp_pkg::GS_KEY: begin
                  if (!fjsp_pkg::is_space(c)) begin
                     if (c == fjsp_pkg::CH_QUOTE) begin
                        gs_in = fjsp_pkg::GS_STRING;
                        in_value_in = 1'b0;
                        khb_in = 1'b0;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
               end
               fjsp_pkg::GS_STRING: begin
                  if (c == fjsp_pkg::CH_QUOTE) begin
                     if (!in_value_ff) begin
                        gs_in = fjsp_pkg::GS_COLON;
                     end else begin
                        entry = khb_ff;
                        gs_in = fjsp_pkg::GS_AFTER;
                     end
                  end else if (c == fjsp_pkg::CH_BSLASH) begin
                     gs_in = fjsp_pkg::GS_ESCAPE;
                  end else begin
                     str_byte[0] = c;
                     str_cnt = 2'd1;
                  end
               end
               fjsp_pkg::GS_ESCAPE: begin
                  gs_in = fjsp_pkg::GS_STRING;
                  str_cnt = 2'd1;
                  unique case (c)
                     fjsp_pkg::CH_QUOTE:  str_byte[0] = 8'h22;
                     fjsp_pkg::CH_BSLASH: str_byte[0] = 8'h5C;
                     fjsp_pkg::CH_SLASH:  str_byte[0] = 8'h2F;
                     fjsp_pkg::CH_LOW_B:  str_byte[0] = 8'h08;
                     fjsp_pkg::CH_LOW_F:  str_byte[0] = 8'h0C;
                     fjsp_pkg::CH_LOW_N:  str_byte[0] = 8'h0A;
                     fjsp_pkg::CH_LOW_R:  str_byte[0] = 8'h0D;
                     fjsp_pkg::CH_LOW_T:  str_byte[0] = 8'h09;
                     fjsp_pkg::CH_LOW_U: begin
                        str_cnt = 2'd0;
                        hex_in = '0;
                        hex_seen_in = '0;
                        gs_in = fjsp_pkg::GS_HEX;
                     end
                     default: begin
                        str_cnt = 2'd0;
                        err_in = 1'b1;
                     end
                  endcase
               end
               fjsp_pkg::GS_HEX: begin
                  if (!hexd[4]) begin
                     err_in = 1'b1;
                  end else begin
                     hex_in = code;
                     if (hex_seen_ff != 2'd3) begin
                        hex_seen_in = hex_seen_ff + 2'd1;
                     end else begin
                        hex_seen_in = '0;
                        gs_in = fjsp_pkg::GS_STRING;
                        if (code <= fjsp_pkg::UTF8_MAX1) begin
                           str_byte[0] = code[7:0];
                           str_cnt = 2'd1;
                        end else if (code <= fjsp_pkg::UTF8_MAX2) begin
                           str_byte[0] = fjsp_pkg::UTF8_LEAD2 | {3'b000, code[10:6]};
                           str_byte[1] = fjsp_pkg::UTF8_CONT | {2'b00, code[5:0]};
                           str_cnt = 2'd2;
                        end else begin
                           str_byte[0] = fjsp_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]};
                           str_byte[1] = fjsp_pkg::UTF8_CONT | {2'b00, code[11:6]};
                           str_byte[2] = fjsp_pkg::UTF8_CONT | {2'b00, code[5:0]};
                           str_cnt = 2'd3;
                        end
                     end
                  end
               end
               fjsp_pkg::GS_COLON: begin
                  if (!fjsp_pkg::is_space(c)) begin
                     if (c == fjsp_pkg::CH_COLON) gs_in = fjsp_pkg::GS_VALUE;
                     else err_in = 1'b1;
                  end
               end
               fjsp_pkg::GS_VALUE: begin
                  if (!fjsp_pkg::is_space(c)) begin
                     if (c == fjsp_pkg::CH_QUOTE) begin
                        gs_in = fjsp_pkg::GS_STRING;
                        in_value_in = 1'b1;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
               end
               fjsp_pkg::GS_AFTER: begin
                  if (!fjsp_pkg::is_space(c)) begin
                     if (c == fjsp_pkg::CH_COMMA) gs_in = fjsp_pkg::GS_KEY;
                     else if (c == fjsp_pkg::CH_RBRACE) gs_in = fjsp_pkg::GS_DONE;
                     else err_in = 1'b1;
                  end
               end
               fjsp_pkg::GS_DONE: begin
                  if (!fjsp_pkg::is_space(c)) err_in = 1'b1;
               end
               default: err_in = 1'b1;
            endcase
            if (!in_value_ff && str_cnt != 2'd0) khb_in = 1'b1;
         end
         if (in_item_ff.final_byte) begin
            finish      = 1'b1;
            bad         = err_in || (gs_in != fjsp_pkg::GS_DONE);
            gs_in       = fjsp_pkg::GS_OPEN;
            in_value_in = 1'b0;
            khb_in      = 1'b0;
            hex_in      = '0;
            hex_seen_in = '0;
            err_in      = 1'b0;
         end
      end
   end

   // pack results
   assign str_emit = !in_value_ff || khb_ff;
   assign str_kind = in_value_ff ? fjsp_pkg::KIND_VALUE : fjsp_pkg::KIND_KEY;

   always_comb begin
      for (int i = 0; i < fjsp_pkg::MAX_RESULTS; i++) begin
         items[i] = '{out_byte: '0, out_kind: fjsp_pkg::KIND_KEY,
                      parse_status: 1'b0, run_end: 1'b0};
      end
      n_items = '0;
      for (int i = 0; i < 3; i++) begin
         items[i].out_byte = str_byte[i];
         items[i].out_kind = str_kind;
      end
      if (str_emit) n_items = fjsp_pkg::RESULT_CW'(str_cnt);
      if (entry) begin
         items[n_items[fjsp_pkg::RESULT_IW-1:0]].out_byte = '0;
         items[n_items[fjsp_pkg::RESULT_IW-1:0]].out_kind = fjsp_pkg::KIND_ENTRY;
         n_items = n_items + 1'b1;
      end
      if (finish) begin
         items[n_items[fjsp_pkg::RESULT_IW-1:0]].out_byte = '0;
         items[n_items[fjsp_pkg::RESULT_IW-1:0]].out_kind = fjsp_pkg::KIND_FINISH;
         items[n_items[fjsp_pkg::RESULT_IW-1:0]].parse_status = bad;
         n_items = n_items + 1'b1;
      end
      if (n_items != '0) begin
         items[fjsp_pkg::RESULT_IW'(n_items - 1'b1)].run_end = 1'b1;
      end
   end

   // result queue: shift out at the head, append behind the survivors
   assign count_pop = count_ff - fjsp_pkg::QUEUE_CW'(pop);

   always_comb begin
      logic [fjsp_pkg::QUEUE_CW-1:0] slot;
      logic [fjsp_pkg::QUEUE_CW-1:0] offs;
      for (int i = 0; i < fjsp_pkg::QUEUE_DEPTH; i++) begin
         slot = fjsp_pkg::QUEUE_CW'(i);
         offs = slot - count_pop;
         if (pop && i < fjsp_pkg::QUEUE_DEPTH - 1) queue_in[i] = queue_ff[i + 1];
         else queue_in[i] = queue_ff[i];
         if (move && slot >= count_pop
             && slot < count_pop + fjsp_pkg::QUEUE_CW'(n_items)) begin
            queue_in[i] = items[offs[fjsp_pkg::RESULT_IW-1:0]];
         end
      end
      count_in = count_pop + (move ? fjsp_pkg::QUEUE_CW'(n_items) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         gs_ff       <= fjsp_pkg::GS_OPEN;
         in_value_ff <= 1'b0;
         khb_ff      <= 1'b0;
         hex_ff      <= '0;
         hex_seen_ff <= '0;
         err_ff      <= 1'b0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         gs_ff       <= gs_in;
         in_value_ff <= in_value_in;
         khb_ff      <= khb_in;
         hex_ff      <= hex_in;
         hex_seen_ff <= hex_seen_in;
         err_ff      <= err_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_item_ff <= req_chan.payload;
      end
      queue_ff <= queue_in;
   end

endmodule

>>> src/fjsp_checker.sv
// ----------------------------------------------------------------------------
// fjsp_checker
// Port-level checks of the flat JSON object stream parser.
// ----------------------------------------------------------------------------
module fjsp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fjsp_pkg::rsp_item_type rsp_payload
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // document finished closes the run of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_kind == fjsp_pkg::KIND_FINISH |-> rsp_payload.run_end)
      else $error("finish without run end");

   // status only on finish
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_kind != fjsp_pkg::KIND_FINISH
      |-> !rsp_payload.parse_status)
      else $error("status outside finish");

   // marks carry no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.out_kind == fjsp_pkg::KIND_ENTRY
                    || rsp_payload.out_kind == fjsp_pkg::KIND_FINISH)
      |-> rsp_payload.out_byte == 8'h00)
      else $error("mark with nonzero byte");

endmodule

bind flat_json_object_stream_parser fjsp_checker u_fjsp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
